/* hw/rtl/ilist_pkg.sv */
package ilist_pkg;

  // Operation codes carried on the opcode field.
  typedef enum logic [1:0] {
    OP_INSERT  = 2'd0,
    OP_UPDATE  = 2'd1,
    OP_DELETE  = 2'd2,
    OP_DISPLAY = 2'd3
  } ilist_op_t;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2,
    ST_EMPTY = 2'd3
  } ilist_status_t;

  // Controller states.
  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_EXEC = 2'd1,
    S_EMIT = 2'd2
  } ilist_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;  // capture the incoming request
    logic exec;  // check and apply the captured operation
    logic pop;   // the current result was taken
  } ilist_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic last;  // the current result closes the operation
  } ilist_stat_t;

endpackage

/* hw/rtl/ilist_ctrl.sv */
module ilist_ctrl
  import ilist_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  output logic        out_valid,
  input  logic        out_stall,
  input  ilist_stat_t stat,
  output ilist_cmd_t  cmd
);

  ilist_state_t state;
  ilist_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_stall   = 1'b1;
    out_valid  = 1'b0;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec   = 1'b1;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        out_valid = 1'b1;
        if (!out_stall) begin
          cmd.pop = 1'b1;
          if (stat.last) begin
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

/* hw/rtl/ilist_dp.sv */
module ilist_dp
  import ilist_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  ilist_cmd_t           cmd,
  input  logic [1:0]           opcode,
  input  logic [4:0]           position,
  input  logic signed [31:0]   new_value,
  output logic [3:0]           slot,
  output logic signed [31:0]   entry_value,
  output logic                 last,
  output logic [1:0]           status,
  output ilist_stat_t          stat
);

  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int IW   = $clog2(CAPACITY);
  localparam int CMPW = (CW > 5) ? CW : 5;

  logic signed [31:0] entries      [CAPACITY];
  logic signed [31:0] entries_next [CAPACITY];
  logic [CW-1:0]      cnt;
  logic [CW-1:0]      cnt_after;
  logic [IW-1:0]      idx;
  ilist_op_t          op;
  logic [4:0]         pos;
  logic signed [31:0] val;
  ilist_status_t      st;
  ilist_status_t      err;
  logic [CMPW-1:0]    pos_ext;
  logic [CMPW-1:0]    cnt_ext;

  assign pos_ext = CMPW'(pos);
  assign cnt_ext = CMPW'(cnt);

  // Checks, list update on execute, and rotation of the list by one place
  // per result so that entry zero is always the one being listed.
  always_comb begin
    err          = ST_OK;
    entries_next = entries;
    cnt_after    = cnt;
    case (op)
      OP_INSERT: begin
        if (cnt == CW'(CAPACITY)) begin
          err = ST_FULL;
        end else if (pos_ext > cnt_ext) begin
          err = ST_RANGE;
        end
      end
      OP_UPDATE, OP_DELETE: begin
        if (cnt == '0) begin
          err = ST_EMPTY;
        end else if (pos_ext >= cnt_ext) begin
          err = ST_RANGE;
        end
      end
      default: begin
      end
    endcase

    if (cmd.exec && err == ST_OK) begin
      case (op)
        OP_INSERT: begin
          for (int i = 1; i < CAPACITY; i++) begin
            if (CMPW'(i) > pos_ext) begin
              entries_next[i] = entries[i-1];
            end
          end
          for (int i = 0; i < CAPACITY; i++) begin
            if (CMPW'(i) == pos_ext) begin
              entries_next[i] = val;
            end
          end
          cnt_after = cnt + CW'(1);
        end
        OP_UPDATE: begin
          for (int i = 0; i < CAPACITY; i++) begin
            if (CMPW'(i) == pos_ext) begin
              entries_next[i] = val;
            end
          end
        end
        OP_DELETE: begin
          for (int i = 0; i < CAPACITY - 1; i++) begin
            if (CMPW'(i) >= pos_ext) begin
              entries_next[i] = entries[i+1];
            end
          end
          cnt_after = cnt - CW'(1);
        end
        default: begin
        end
      endcase
    end else if (cmd.pop && st == ST_OK) begin
      for (int i = 0; i < CAPACITY - 1; i++) begin
        if (CW'(i) < cnt) begin
          entries_next[i] = entries[i+1];
        end
      end
      for (int i = 0; i < CAPACITY; i++) begin
        if (CW'(i + 1) == cnt) begin
          entries_next[i] = entries[0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < CAPACITY; i++) begin
      entries[i] <= entries_next[i];
    end
    if (cmd.load) begin
      op  <= ilist_op_t'(opcode);
      pos <= position;
      val <= new_value;
    end
    if (cmd.exec) begin
      idx <= '0;
      if (err != ST_OK) begin
        st <= err;
      end else if (cnt_after == '0) begin
        st <= ST_EMPTY;
      end else begin
        st <= ST_OK;
      end
    end else if (cmd.pop) begin
      idx <= idx + IW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (cmd.exec && err == ST_OK) begin
      cnt <= cnt_after;
    end
  end

  always_comb begin
    if (st != ST_OK) begin
      slot        = 4'd0;
      entry_value = 32'sd0;
      last        = 1'b1;
    end else begin
      slot        = 4'(idx);
      entry_value = entries[0];
      last        = (CW'(idx) + CW'(1)) == cnt;
    end
  end

  assign status    = st;
  assign stat.last = last;

endmodule

/* hw/rtl/indexed_list_insert_delete.sv */
// Indexed list with insert, update, delete and display at an index.
// Requests arrive on in_valid / in_stall with opcode, position and
// new_value; a request is taken when in_valid is high and in_stall is low.
// Results leave on out_valid / out_stall with slot, entry_value, last and
// status; a result is taken when out_valid is high and out_stall is low.
// A successful request lists every entry in order, one result per cycle
// while out_stall is low, with last set on the final one; an empty list
// gives one result with status empty, and a rejected request gives one
// error result and leaves the list unchanged.
// Steps: the request is taken in the idle state, checked and the list
// shifted in the execute state, then its results are listed in the emit
// state. One request is in work at a time: in_stall stays high from the
// request until its last result is taken.
// While out_stall is high the current result holds steady on the ports.
// Reset clears the entry count, so the list starts empty; entry storage is
// not cleared and needs no clearing pass.
module indexed_list_insert_delete
  import ilist_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         opcode,
  input  logic [4:0]         position,
  input  logic signed [31:0] new_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [3:0]         slot,
  output logic signed [31:0] entry_value,
  output logic               last,
  output logic [1:0]         status
);

  // Commands and status between the controller and the datapath.
  ilist_cmd_t  cmd;
  ilist_stat_t stat;

  // The controller sequences take, execute and list phases.
  ilist_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  // The datapath holds the list and the count, and rotates the list by one
  // place per result so that the listed entry is always at the head.
  ilist_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .opcode      (opcode),
    .position    (position),
    .new_value   (new_value),
    .slot        (slot),
    .entry_value (entry_value),
    .last        (last),
    .status      (status),
    .stat        (stat)
  );

`ifndef SYNTHESIS
  // No new request is taken while results are being listed.
  a_no_take_while_listing: assert property (
    @(posedge clk) disable iff (rst) out_valid |-> in_stall
  ) else $error("request taken while results pending");

  // The cycle after a request is taken is spent executing it.
  a_exec_gap: assert property (
    @(posedge clk) disable iff (rst) (in_valid && !in_stall) |=> !out_valid
  ) else $error("result shown in the execute cycle");

  // A taken result that is not the last is followed by another result.
  a_list_continues: assert property (
    @(posedge clk) disable iff (rst)
      (out_valid && !out_stall && !last) |=> out_valid
  ) else $error("list ended without last");

  // Error and empty results always stand alone.
  a_single_result: assert property (
    @(posedge clk) disable iff (rst)
      (out_valid && status != ST_OK) |-> last
  ) else $error("status result not marked last");
`endif

endmodule

/* bench/indexed_list_insert_delete_test.sv */
`timescale 1ns / 1ps

// Checks the indexed list block on its request and result channels.
// A shadow copy of the list is kept here. Every accepted request is applied
// to it, and the results that the request must produce are queued. Every
// accepted result is then compared, field by field, with the oldest queued
// result. The directed table comes first, then a long random run that
// swings the list between empty and full so that every error path and every
// list length is exercised.
module indexed_list_insert_delete_test;
  import ilist_pkg::*;

  localparam int CAPACITY = 16;
  // Cycles with nothing taken on either channel before the run is declared hung.
  // The worst honest stretch is a sender gap plus a stall burst plus the
  // execute step of the block, far below this.
  localparam int IDLE_LIMIT = 3000;
  localparam int RANDOM_REQUESTS = 400;
  // Cycles waited after the run has drained, before the summary is printed.
  localparam int DRAIN_CYCLES = 20;

  // One result as it leaves the block.
  typedef struct packed {
    logic [3:0]         slot;
    logic signed [31:0] value;
    logic               last;
    ilist_status_t      status;
  } list_result_t;

  // One row of the directed table. Where has_fixed is set, the request must
  // answer with a single result of fixed_status and leave the list alone.
  typedef struct packed {
    ilist_op_t          op;
    logic [4:0]         pos;
    logic signed [31:0] val;
    logic               has_fixed;
    ilist_status_t      fixed_status;
  } list_request_t;

  // Patterns that the result side uses to push back.
  typedef enum int {
    STALL_NONE,
    STALL_COIN,
    STALL_LIGHT,
    STALL_BURSTS
  } stall_mode_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [1:0]         opcode = OP_DISPLAY;
  logic [4:0]         position = '0;
  logic signed [31:0] new_value = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [3:0]         slot;
  logic signed [31:0] entry_value;
  logic               last;
  logic [1:0]         status;

  indexed_list_insert_delete #(
    .CAPACITY(CAPACITY)
  ) dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .opcode     (opcode),
    .position   (position),
    .new_value  (new_value),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .slot       (slot),
    .entry_value(entry_value),
    .last       (last),
    .status     (status)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow of the list and the results still owed by the block.
  logic signed [31:0] shadow_entries [CAPACITY];
  int unsigned        shadow_count = 0;
  list_result_t       owed_results [$];

  int failures = 0;
  int results_checked = 0;
  int requests_by_op [4] = '{0, 0, 0, 0};
  int results_by_status [4] = '{0, 0, 0, 0};
  int deepest_list = 0;
  int burst_left = 0;

  // A rejected request, or a list left empty, answers with one lone result.
  function automatic void owe_single(ilist_status_t st);
    list_result_t r;
    r.slot   = '0;
    r.value  = '0;
    r.last   = 1'b1;
    r.status = st;
    owed_results.push_back(r);
  endfunction

  // A successful request lists every entry in order, the final one marked.
  function automatic void owe_listing();
    list_result_t r;
    if (shadow_count == 0) begin
      owe_single(ST_EMPTY);
      return;
    end
    for (int i = 0; i < shadow_count; i++) begin
      r.slot   = i[3:0];
      r.value  = shadow_entries[i];
      r.last   = (i + 1 == shadow_count);
      r.status = ST_OK;
      owed_results.push_back(r);
    end
  endfunction

  // Applies one request to the shadow list and queues what it must produce.
  // Note the order of checks on insert: a full list wins over a bad index.
  function automatic void apply_to_shadow(ilist_op_t op, logic [4:0] pos,
                                          logic signed [31:0] val);
    case (op)
      OP_INSERT: begin
        if (shadow_count >= CAPACITY) begin
          owe_single(ST_FULL);
          return;
        end
        if (pos > shadow_count) begin
          owe_single(ST_RANGE);
          return;
        end
        for (int i = int'(shadow_count); i > pos; i--)
          shadow_entries[i] = shadow_entries[i - 1];
        shadow_entries[pos] = val;
        shadow_count++;
      end
      OP_UPDATE, OP_DELETE: begin
        if (shadow_count == 0) begin
          owe_single(ST_EMPTY);
          return;
        end
        if (pos >= shadow_count) begin
          owe_single(ST_RANGE);
          return;
        end
        if (op == OP_UPDATE) begin
          shadow_entries[pos] = val;
        end else begin
          for (int i = int'(pos); i + 1 < shadow_count; i++)
            shadow_entries[i] = shadow_entries[i + 1];
          shadow_count--;
        end
      end
      default: begin
      end
    endcase
    if (shadow_count > deepest_list) deepest_list = int'(shadow_count);
    owe_listing();
  endfunction

  // Presents one request and holds it until the block takes it. The caller
  // is always just past a rising edge, so the new payload lands there too.
  task automatic send_request(list_request_t req);
    opcode    <= req.op;
    position  <= req.pos;
    new_value <= req.val;
    in_valid  <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    requests_by_op[req.op]++;
    if (req.has_fixed) owe_single(req.fixed_status);
    else apply_to_shadow(req.op, req.pos, req.val);
  endtask

  // The sender runs in bursts; between bursts valid drops for a few cycles.
  // Now and then a burst runs long so that back-to-back requests occur.
  task automatic pace_sender();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = $urandom_range(1, 12);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(15, 40) : $urandom_range(0, 6);
    end
  endtask

  // Holds off new requests until every owed result has been taken.
  task automatic wait_until_drained();
    in_valid <= 1'b0;
    while (owed_results.size() != 0) @(posedge clk);
  endtask

  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(0, 11))
      0:       return 32'sh7FFF_FFFF;
      1:       return 32'sh8000_0000;
      2:       return -32'sd1;
      3:       return 32'sd0;
      default: return $urandom;
    endcase
  endfunction

  // Builds one random request. Most requests are legal for the current
  // list, steered by whether the list is being grown or drained; the rest
  // are noise with any opcode and any position, including past the end.
  function automatic list_request_t pick_request(ref bit growing);
    list_request_t req;
    int roll;
    if (shadow_count == CAPACITY && $urandom_range(0, 2) == 0) growing = 1'b0;
    if (shadow_count == 0 && $urandom_range(0, 2) == 0) growing = 1'b1;
    req.has_fixed    = 1'b0;
    req.fixed_status = ST_OK;
    req.val          = pick_value();
    roll = $urandom_range(0, 99);
    if (roll < 10) begin
      req.op  = ilist_op_t'($urandom_range(0, 3));
      req.pos = 5'($urandom_range(0, 31));
      return req;
    end
    if (growing) begin
      req.op = (roll < 70) ? OP_INSERT : (roll < 85) ? OP_UPDATE :
               (roll < 95) ? OP_DISPLAY : OP_DELETE;
    end else begin
      req.op = (roll < 65) ? OP_DELETE : (roll < 80) ? OP_UPDATE :
               (roll < 90) ? OP_DISPLAY : OP_INSERT;
    end
    if (req.op == OP_INSERT) req.pos = 5'($urandom_range(0, shadow_count));
    else if (shadow_count == 0) req.pos = '0;
    else req.pos = 5'($urandom_range(0, shadow_count - 1));
    return req;
  endfunction

  // Result side: the stall pattern changes mode at random intervals, so
  // there are stretches with no stall at all, coin flips, light stalls and
  // regular long bursts.
  stall_mode_t stall_mode = STALL_NONE;
  int          stall_phase_left = 0;
  int unsigned cycle_count = 0;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (stall_phase_left == 0) begin
      stall_mode       <= stall_mode_t'($urandom_range(0, 3));
      stall_phase_left <= $urandom_range(20, 120);
    end else begin
      stall_phase_left <= stall_phase_left - 1;
    end
    case (stall_mode)
      STALL_NONE:  out_stall <= 1'b0;
      STALL_COIN:  out_stall <= ($urandom_range(0, 1) == 0);
      STALL_LIGHT: out_stall <= ($urandom_range(0, 9) < 2);
      default:     out_stall <= ((cycle_count % 16) < 10);
    endcase
  end

  function automatic void compare_field(string name, longint want, longint got);
    if (want != got) begin
      failures++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endfunction

  // Every result taken is matched against the oldest owed result.
  always @(posedge clk) begin
    list_result_t want;
    if (!rst && out_valid && !out_stall) begin
      results_by_status[status]++;
      if (owed_results.size() == 0) begin
        failures++;
        $display("%0t: unexpected result, actual slot %0d value %0d last %0b status %0d",
                 $time, slot, entry_value, last, status);
      end else begin
        want = owed_results.pop_front();
        results_checked++;
        compare_field("slot", want.slot, slot);
        compare_field("entry_value", want.value, entry_value);
        compare_field("last", want.last, last);
        compare_field("status", want.status, status);
      end
    end
  end

  // Watchdog: a run that stops taking requests and results has hung.
  int idle_cycles = 0;

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no progress for %0d cycles, %0d results still owed",
               $time, IDLE_LIMIT, owed_results.size());
      $display("RESULT: ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Directed table. Rows with a fixed status are errors or an empty list,
  // which leave the list as it was. The full-list insert is reached by the
  // random run, which fills the list to capacity over and over.
  list_request_t directed_rows [18];

  initial begin
    bit growing;
    directed_rows = '{
      // Empty list right after reset.
      '{OP_DISPLAY, 5'd0,  32'sd0,          1'b1, ST_EMPTY},
      '{OP_UPDATE,  5'd0,  32'sd5,          1'b1, ST_EMPTY},
      '{OP_DELETE,  5'd31, 32'sd0,          1'b1, ST_EMPTY},
      '{OP_INSERT,  5'd1,  32'sd9,          1'b1, ST_RANGE},
      // Build a short list: first entry, append at the end, push at the front.
      '{OP_INSERT,  5'd0,  32'sh7FFF_FFFF,  1'b0, ST_OK},
      '{OP_INSERT,  5'd1,  32'sh8000_0000,  1'b0, ST_OK},
      '{OP_INSERT,  5'd0,  -32'sd1,         1'b0, ST_OK},
      // Positions past the end for each kind of access.
      '{OP_INSERT,  5'd31, 32'sd7,          1'b1, ST_RANGE},
      '{OP_UPDATE,  5'd3,  32'sd1,          1'b1, ST_RANGE},
      '{OP_DELETE,  5'd31, 32'sd0,          1'b1, ST_RANGE},
      // Legal edits in the middle and at the top.
      '{OP_UPDATE,  5'd2,  32'sd0,          1'b0, ST_OK},
      '{OP_INSERT,  5'd1,  32'sh5555_5555,  1'b0, ST_OK},
      '{OP_DELETE,  5'd1,  32'sd0,          1'b0, ST_OK},
      '{OP_DISPLAY, 5'd0,  32'sd0,          1'b0, ST_OK},
      '{OP_DELETE,  5'd2,  32'sd0,          1'b0, ST_OK},
      // Drain to empty; the last delete succeeds and reports an empty list.
      '{OP_DELETE,  5'd0,  32'sd0,          1'b0, ST_OK},
      '{OP_DELETE,  5'd0,  32'sd0,          1'b0, ST_OK},
      '{OP_UPDATE,  5'd0,  32'sd0,          1'b1, ST_EMPTY}
    };
    growing = 1'b1;

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[k]) begin
      send_request(directed_rows[k]);
      pace_sender();
    end

    // Let the directed part finish before the random run starts.
    wait_until_drained();
    @(posedge clk);

    for (int n = 1; n <= RANDOM_REQUESTS; n++) begin
      send_request(pick_request(growing));
      if (n % 100 == 0) wait_until_drained();
      else pace_sender();
    end

    wait_until_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d requests: %0d insert, %0d update, %0d delete, %0d display.",
             requests_by_op[OP_INSERT] + requests_by_op[OP_UPDATE] +
             requests_by_op[OP_DELETE] + requests_by_op[OP_DISPLAY],
             requests_by_op[OP_INSERT], requests_by_op[OP_UPDATE],
             requests_by_op[OP_DELETE], requests_by_op[OP_DISPLAY]);
    $display("Checked %0d results (ok %0d, range %0d, full %0d, empty %0d); longest list %0d.",
             results_checked, results_by_status[ST_OK], results_by_status[ST_RANGE],
             results_by_status[ST_FULL], results_by_status[ST_EMPTY], deepest_list);
    if (failures == 0 && owed_results.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches, %0d results never arrived", failures, owed_results.size());
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/ilist_pkg.sv
hw/rtl/ilist_ctrl.sv
hw/rtl/ilist_dp.sv
hw/rtl/indexed_list_insert_delete.sv
bench/indexed_list_insert_delete_test.sv
